// ----- rtl/glpll_pkg.sv -----
// Shared types and constants of the grid phase-locked loop.
`default_nettype none

package glpll_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 21;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int NOM_WIDTH  = 31;
  localparam int STEP_WIDTH = 22;
  localparam int IDX_WIDTH  = 2;

  // Register indexes of the configuration port.
  localparam logic [IDX_WIDTH-1:0] REG_GAIN_CURRENT  = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_GAIN_PREVIOUS = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_NOMINAL_FREQ  = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_TIME_STEP     = 2'd3;

  // Reset values in Q21.
  localparam logic signed [DATA_WIDTH-1:0] RST_GAIN_CURRENT  = 32'sd350170487;
  localparam logic signed [DATA_WIDTH-1:0] RST_GAIN_PREVIOUS = -32'sd348685074;
  localparam logic [NOM_WIDTH-1:0]         RST_NOMINAL_FREQ  = 31'd104857600;
  localparam logic [STEP_WIDTH-1:0]        RST_TIME_STEP     = 22'd210;

  // Upper clamp of the filter output (200.0) and one full cycle (1.0).
  localparam logic signed [DATA_WIDTH-1:0] CLAMP_Q = 32'sd419430400;
  localparam logic signed [DATA_WIDTH-1:0] ONE_Q   = 32'sd2097152;

  // Operand pairs of the shared multiplier.
  localparam logic [1:0] OP_GAIN_CUR_VQ   = 2'd0;
  localparam logic [1:0] OP_GAIN_PREV_ERR = 2'd1;
  localparam logic [1:0] OP_FREQ_STEP     = 2'd2;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] op_sel;
    logic       sum_load;
    logic       filt_load;
    logic       out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/glpll_mul.sv -----
// Shared signed multiplier with a registered product and Q scaling.
`default_nettype none

module glpll_mul
  import glpll_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [DATA_WIDTH-1:0] a,
  input  wire logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0]      q
);

  logic signed [PROD_WIDTH-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
    end
  end

  // Dropping the fraction bits of a two's complement product rounds toward minus infinity.
  assign q = prod[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];

endmodule

`default_nettype wire

// ----- rtl/glpll_seq.sv -----
// Sequencer that steps one sample through the shared multiplier.
`default_nettype none

module glpll_seq
  import glpll_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_free,
  output logic      in_ready,
  output ctrl_t     ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_FILT  = 3'd3;
  localparam logic [2:0] S_MUL_C = 3'd4;
  localparam logic [2:0] S_PHASE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    ctrl.op_sel = OP_GAIN_CUR_VQ;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_MUL_A;
      end
      S_MUL_A: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_GAIN_CUR_VQ;
        state_next  = S_MUL_B;
      end
      S_MUL_B: begin
        ctrl.mul_en   = 1'b1;
        ctrl.op_sel   = OP_GAIN_PREV_ERR;
        ctrl.sum_load = 1'b1;
        state_next    = S_FILT;
      end
      S_FILT: begin
        ctrl.filt_load = 1'b1;
        state_next     = S_MUL_C;
      end
      S_MUL_C: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_FREQ_STEP;
        state_next  = S_PHASE;
      end
      S_PHASE: begin
        // Hold here until the output register can take the result.
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/grid_phase_locked_loop_unit.sv -----
// Top level of the grid phase-locked loop: PI loop filter and phase integrator.
//
//  Channel  Signals                                   Direction  Content
//  in       in_valid, in_ready, vq_sample             sink       q-axis error sample
//  out      out_valid, out_ready, phase, frequency,   source     phase, frequency and
//           filter_out                                           clamped filter output
//  cfg      cfg_we, cfg_index, cfg_data               sink       gains, nominal, step
//
// Each request uses the single 32x32 multiplier three times in
// sequence (two filter products, then the phase increment) with an accumulate step.
// The result is registered in the last step, and the next request is taken once the
// sequencer is back in idle. A stalled output holds the sequencer in its last step,
// while a waiting result does not stop acceptance of the next request.
// Reset is synchronous; it clears the filter and phase state and loads the
// configuration registers with their default values.
`default_nettype none

module grid_phase_locked_loop_unit
  import glpll_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] vq_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      phase,
  output logic signed [DATA_WIDTH-1:0]      frequency,
  output logic signed [DATA_WIDTH-1:0]      filter_out,
  input  wire logic                         cfg_we,
  input  wire logic [IDX_WIDTH-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data
);

  logic signed [DATA_WIDTH-1:0] gain_current;
  logic signed [DATA_WIDTH-1:0] gain_previous;
  logic [NOM_WIDTH-1:0]         nominal_freq;
  logic [STEP_WIDTH-1:0]        time_step;

  logic signed [DATA_WIDTH-1:0] vq_reg;
  logic signed [DATA_WIDTH-1:0] prev_error;
  logic signed [DATA_WIDTH-1:0] filter_acc;
  logic signed [DATA_WIDTH-1:0] phase_acc;
  logic signed [DATA_WIDTH-1:0] sum_reg;
  logic signed [DATA_WIDTH-1:0] filt_reg;
  logic signed [DATA_WIDTH-1:0] freq_reg;

  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [DATA_WIDTH-1:0] mul_b;
  logic signed [DATA_WIDTH-1:0] mul_q;
  logic signed [DATA_WIDTH-1:0] acc_next;
  logic signed [DATA_WIDTH-1:0] clamp_next;
  logic signed [DATA_WIDTH-1:0] phase_sum;
  logic signed [DATA_WIDTH-1:0] phase_next;

  logic  out_free;
  logic  in_take;
  ctrl_t ctrl;

  assign out_free = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  glpll_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  always_comb begin
    unique case (ctrl.op_sel)
      OP_GAIN_CUR_VQ: begin
        mul_a = gain_current;
        mul_b = vq_reg;
      end
      OP_GAIN_PREV_ERR: begin
        mul_a = gain_previous;
        mul_b = prev_error;
      end
      OP_FREQ_STEP: begin
        mul_a = freq_reg;
        mul_b = $signed({{(DATA_WIDTH-STEP_WIDTH){1'b0}}, time_step});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  glpll_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign acc_next   = sum_reg + mul_q;
  assign clamp_next = (acc_next > CLAMP_Q) ? CLAMP_Q : acc_next;
  assign phase_sum  = phase_acc + mul_q;
  // Only one cycle is removed per sample; a negative phase is left alone.
  assign phase_next = (phase_sum > ONE_Q) ? (phase_sum - ONE_Q) : phase_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_current  <= RST_GAIN_CURRENT;
      gain_previous <= RST_GAIN_PREVIOUS;
      nominal_freq  <= RST_NOMINAL_FREQ;
      time_step     <= RST_TIME_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_CURRENT:  gain_current  <= $signed(cfg_data);
        REG_GAIN_PREVIOUS: gain_previous <= $signed(cfg_data);
        REG_NOMINAL_FREQ:  nominal_freq  <= cfg_data[NOM_WIDTH-1:0];
        REG_TIME_STEP:     time_step     <= cfg_data[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      filter_acc <= '0;
      phase_acc  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.filt_load) begin
        filter_acc <= acc_next;
        prev_error <= vq_reg;
      end
      if (ctrl.out_load) begin
        phase_acc <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      vq_reg <= vq_sample;
    end
    if (ctrl.sum_load) begin
      sum_reg <= filter_acc + mul_q;
    end
    if (ctrl.filt_load) begin
      filt_reg <= clamp_next;
      freq_reg <= $signed({1'b0, nominal_freq}) + clamp_next;
    end
    if (ctrl.out_load) begin
      phase      <= phase_next;
      frequency  <= freq_reg;
      filter_out <= filt_reg;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("block took a request while one was in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.filt_load |=> (filt_reg <= CLAMP_Q))
    else $error("filter output above the upper clamp");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
